// File: src/ufcc_pkg.sv
// shared types, constants and crc function for the upgrade frame checker
package ufcc_pkg;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [23:0] END_MARK  = 24'h656E64;
	localparam logic [15:0] LEN_BIAS  = 16'd2;
	localparam logic [16:0] INDEX_MAX = 17'h1FFFF;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_ARM  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_CRC_ERROR    = 3'd1,
		ST_END_MARKER   = 3'd2,
		ST_NOT_ACTIVE   = 3'd3,
		ST_LENGTH_ERROR = 3'd4
	} status_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] packet_id;
		logic [15:0] payload_length;
		logic        upgrade_active;
	} result_t;

	// crc-16/modbus update by one byte, reflected
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// File: src/ufcc_in_if.sv
// valid/ready channel for incoming frame items
interface ufcc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output operation, output data_byte, output last_byte,
		input ready);
	modport sink (input valid, input operation, input data_byte, input last_byte,
		output ready);
endinterface

// File: src/ufcc_out_if.sv
// valid/ready channel for frame verdicts
interface ufcc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] packet_id;
	logic [15:0] payload_length;
	logic        upgrade_active;

	modport source (output valid, output status, output packet_id, output payload_length,
		output upgrade_active, input ready);
	modport sink (input valid, input status, input packet_id, input payload_length,
		input upgrade_active, output ready);
endinterface

// File: src/upgrade_frame_crc_checker_top.sv
// upgrade frame checker: an accepted last byte passes the input register and the verdict
// register to its verdict valid; throughput one item per cycle unless a verdict stalls,
// set by the single-byte crc update from input register to frame state / verdict register
// arm items and non-final bytes give no verdict
// asynchronous active-low reset clears upgrade mode, the frame state (crc to 0xffff)
// and both pipeline valids
module upgrade_frame_crc_checker_top import ufcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ufcc_in_if.sink    frame,
	ufcc_out_if.source verdict
);

	logic     v_s1;
	in_item_t item_s1;
	logic     out_v_q;
	result_t  res_q;
	result_t  res;
	logic     makes_result;
	logic     advance;

	assign makes_result = (item_s1.operation == OP_BYTE) && item_s1.last_byte;
	assign advance      = v_s1 && (!makes_result || !out_v_q || verdict.ready);
	assign frame.ready  = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (frame.ready) begin
			v_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			item_s1.operation <= op_t'(frame.operation);
			item_s1.data_byte <= frame.data_byte;
			item_s1.last_byte <= frame.last_byte;
		end
	end

	ufcc_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance && makes_result) begin
			out_v_q <= 1'b1;
		end else if (verdict.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && makes_result) begin
			res_q <= res;
		end
	end

	assign verdict.valid          = out_v_q;
	assign verdict.status         = res_q.status;
	assign verdict.packet_id      = res_q.packet_id;
	assign verdict.payload_length = res_q.payload_length;
	assign verdict.upgrade_active = res_q.upgrade_active;

endmodule

// File: src/ufcc_frame.sv
// frame state, crc accumulation and verdict logic
module ufcc_frame import ufcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output result_t  result
);

	logic        mode_q;
	logic [16:0] idx_q;
	logic [23:0] head_q;
	logic [15:0] id_q;
	logic [15:0] len_q;
	logic [15:0] crc_q;
	logic [15:0] rx_q;

	logic        mode_n;
	logic [16:0] idx_n;
	logic [23:0] head_n;
	logic [15:0] id_n;
	logic [15:0] len_n;
	logic [15:0] crc_n;
	logic [15:0] rx_n;
	logic [17:0] crc_lim;
	logic        len_ok;
	logic [15:0] plen;
	status_t     status;

	always_comb begin
		head_n  = head_q;
		id_n    = id_q;
		len_n   = len_q;
		crc_n   = crc_q;
		rx_n    = rx_q;
		crc_lim = {2'b00, len_q} + 18'd2;
		if (idx_q < 17'd3) begin
			head_n = {head_q[15:0], item.data_byte};
		end
		if (idx_q == 17'd0) begin
			id_n = {item.data_byte, 8'h00};
		end else if (idx_q == 17'd1) begin
			id_n = {id_q[15:8], item.data_byte};
		end else if (idx_q == 17'd2) begin
			len_n = {item.data_byte, 8'h00};
		end else if (idx_q == 17'd3) begin
			len_n = {len_q[15:8], item.data_byte};
		end else if (len_q >= LEN_BIAS) begin
			if ({1'b0, idx_q} < crc_lim) begin
				crc_n = crc_byte(crc_q, item.data_byte);
			end else if ({1'b0, idx_q} == crc_lim) begin
				rx_n = {item.data_byte, 8'h00};
			end else if ({1'b0, idx_q} == crc_lim + 18'd1) begin
				rx_n = {rx_q[15:8], item.data_byte};
			end
		end
		idx_n = (idx_q == INDEX_MAX) ? idx_q : idx_q + 17'd1;

		len_ok = len_n >= LEN_BIAS;
		plen   = (idx_n >= 17'd4 && len_ok) ? len_n - LEN_BIAS : 16'd0;

		mode_n = mode_q;
		priority if (!mode_q) begin
			status = ST_NOT_ACTIVE;
		end else if (idx_n >= 17'd3 && head_n == END_MARK) begin
			status = ST_END_MARKER;
			mode_n = 1'b0;
		end else if (idx_n < 17'd4 || !len_ok
				|| {1'b0, idx_n} < {2'b00, len_n} + 18'd4) begin
			status = ST_LENGTH_ERROR;
		end else if (rx_n == crc_n) begin
			status = ST_OK;
		end else begin
			status = ST_CRC_ERROR;
			mode_n = 1'b0;
		end

		result.status         = status;
		result.packet_id      = id_n;
		result.payload_length = plen;
		result.upgrade_active = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			idx_q  <= '0;
			head_q <= '0;
			id_q   <= '0;
			len_q  <= '0;
			crc_q  <= CRC_INIT;
			rx_q   <= '0;
		end else if (step) begin
			if (item.operation == OP_ARM) begin
				mode_q <= 1'b1;
			end else if (item.last_byte) begin
				// verdict given, frame fields start over
				mode_q <= mode_n;
				idx_q  <= '0;
				head_q <= '0;
				id_q   <= '0;
				len_q  <= '0;
				crc_q  <= CRC_INIT;
				rx_q   <= '0;
			end else begin
				idx_q  <= idx_n;
				head_q <= head_n;
				id_q   <= id_n;
				len_q  <= len_n;
				crc_q  <= crc_n;
				rx_q   <= rx_n;
			end
		end
	end

endmodule
